// ===== rtl/awc_pkg.sv =====
// ----------------------------------------------------------------------------
// awc_pkg
// Shared widths, constants and the CORDIC arctangent table for the Ackermann
// wheel command pipeline.
// ----------------------------------------------------------------------------
package awc_pkg;

	localparam int ANGLE_FRAC_BITS = 12;
	localparam int CORDIC_STEPS    = 16;

	// internal angle scale: rad * 2^ZF
	localparam int ZF  = 30;
	localparam int ZSH = ZF - ANGLE_FRAC_BITS;
	localparam int ZW  = 34;
	localparam int ZRW = ZW + 1;

	localparam int RW    = 32;   // rotation CORDIC x/y
	localparam int DW_IN = 46;   // n, d0, d1, 2*L*cos
	localparam int VW    = 48;   // vectoring CORDIC x/y
	localparam int AW    = 14;   // steering angle out
	localparam int SW    = 16;   // drive speed
	localparam int RTW   = 20;   // wheel rate out

	localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1686629713;
	localparam logic signed [RW-1:0] CORDIC_X0 = 32'sd268435456;

	localparam int AMAX   = (1309 * (1 << ANGLE_FRAC_BITS) + 500) / 1000;
	localparam int HP_OUT = (1686629713 + (1 << (ZSH - 1))) >> ZSH;

	// restoring divider
	localparam int DIV_NW = 53;
	localparam int DIV_DW = 29;

	// configuration register indexes
	localparam logic [2:0] CFG_WHEELBASE = 3'd0;
	localparam logic [2:0] CFG_TRACK     = 3'd1;
	localparam logic [2:0] CFG_RADIUS    = 3'd2;
	localparam logic [2:0] CFG_THRESHOLD = 3'd3;
	localparam logic [2:0] CFG_OUTER     = 3'd4;
	localparam logic [2:0] CFG_INNER     = 3'd5;

	function automatic logic signed [ZW-1:0] atan_z(input int unsigned idx);
		case (idx)
			0:  return 34'sd843314857;
			1:  return 34'sd497837829;
			2:  return 34'sd263043837;
			3:  return 34'sd133525159;
			4:  return 34'sd67021687;
			5:  return 34'sd33543516;
			6:  return 34'sd16775851;
			7:  return 34'sd8388437;
			8:  return 34'sd4194283;
			9:  return 34'sd2097149;
			10: return 34'sd1048576;
			11: return 34'sd524288;
			12: return 34'sd262144;
			13: return 34'sd131072;
			14: return 34'sd65536;
			15: return 34'sd32768;
			16: return 34'sd16384;
			17: return 34'sd8192;
			18: return 34'sd4096;
			19: return 34'sd2048;
			20: return 34'sd1024;
			21: return 34'sd512;
			22: return 34'sd256;
			23: return 34'sd128;
			24: return 34'sd64;
			25: return 34'sd32;
			26: return 34'sd16;
			27: return 34'sd8;
			28: return 34'sd4;
			29: return 34'sd2;
			30: return 34'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== rtl/ackermann_wheel_command.sv =====
// ----------------------------------------------------------------------------
// ackermann_wheel_command
// Drive command to wheel command: front steering angles by Ackermann geometry
// and front / rear wheel rates, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one command word per clock while s_tready is high and returns one
// result word per command, in order. The input register, 16-stage sin/cos
// CORDIC, two multiply/add stages, then the rate path with two chained
// 53-stage restoring dividers set the depth; the two atan2 CORDICs
// run beside it and their angles wait in a delay line. A two-word output
// buffer parts the sides; s_tready drops only when both entries are held.
// Configuration is taken at any cycle but must only change while idle.
// Angles in 1/4096 rad, speeds 1/256 m/s, rates 1/128 rad/s (saturated).
// ----------------------------------------------------------------------------
module ackermann_wheel_command (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // steer_angle[13:0], drive_speed[29:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // left_steer[13:0], right_steer[27:14],
	                               // front_rate[47:28], rear_left_rate[67:48],
	                               // rear_right_rate[87:68]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_wdata
);
	import awc_pkg::*;

	typedef struct packed {
		logic signed [RTW-1:0] rear_right_rate;
		logic signed [RTW-1:0] rear_left_rate;
		logic signed [RTW-1:0] front_rate;
		logic signed [AW-1:0]  right_steer;
		logic signed [AW-1:0]  left_steer;
	} res_t;

	typedef struct packed {
		logic signed [AW-1:0] right_steer;
		logic signed [AW-1:0] left_steer;
	} ang_t;

	// rides along the first divider
	typedef struct packed {
		logic signed [SW-1:0] speed;
		logic                 dd_pos;
		logic                 neg0;
		logic                 neg1;
	} sb1_t;

	// rides along the second divider
	typedef struct packed {
		logic negf;
		logic neg0;
		logic neg1;
	} sb2_t;

	localparam logic signed [AW-1:0] PHI_MAX = AW'(AMAX);
	localparam int ANG_DLY = 2 * DIV_NW - CORDIC_STEPS + 1;
	localparam logic [DIV_NW-1:0] SPEED_LIM = DIV_NW'(1) << 40;
	localparam logic signed [RTW-1:0] RATE_MAX = {1'b0, {(RTW-1){1'b1}}};
	localparam logic signed [RTW-1:0] RATE_MIN = {1'b1, {(RTW-1){1'b0}}};
	localparam logic [DIV_NW-1:0] RATE_POS_LIM = DIV_NW'(RATE_MAX);
	localparam logic [DIV_NW-1:0] RATE_NEG_LIM = DIV_NW'(RATE_MAX) + DIV_NW'(1);

	// ---------------- configuration ----------------
	logic [13:0] wheelbase_q, track_q;
	logic [11:0] radius_q;
	logic [12:0] thr_q, outer_q, inner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 14'd3301;
			track_q     <= 14'd1458;
			radius_q    <= 12'd336;
			thr_q       <= 13'd3277;
			outer_q     <= 13'd3285;
			inner_q     <= 13'd2529;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WHEELBASE: wheelbase_q <= cfg_wdata;
				CFG_TRACK:     track_q     <= cfg_wdata;
				CFG_RADIUS:    radius_q    <= cfg_wdata[11:0];
				CFG_THRESHOLD: thr_q       <= cfg_wdata[12:0];
				CFG_OUTER:     outer_q     <= cfg_wdata[12:0];
				CFG_INNER:     inner_q     <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// whole pipe moves together; it halts only with the buffer full
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	logic       en, push, pop;
	res_t       buf_q [2];
	res_t       res_r5;
	logic       v_r5;

	assign en       = (count_q != 2'd2);
	assign s_tready = en;
	assign push     = en && v_r5;
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;

	// ---------------- input stage ----------------
	logic signed [AW-1:0] in_angle, phi_c, phi_a1;
	logic signed [SW-1:0] in_speed, spd_a1;
	logic                 v_a1;

	assign in_angle = $signed(s_tdata[13:0]);
	assign in_speed = $signed(s_tdata[29:14]);

	always_comb begin
		if (in_angle > PHI_MAX) begin
			phi_c = PHI_MAX;
		end else if (in_angle < -PHI_MAX) begin
			phi_c = -PHI_MAX;
		end else begin
			phi_c = in_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a1 <= 1'b0;
		end else if (en) begin
			v_a1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_a1 <= phi_c;
			spd_a1 <= in_speed;
		end
	end

	// ---------------- sin / cos ----------------
	logic signed [ZW-1:0] rot_z;
	logic                 rot_valid;
	logic signed [RW-1:0] rot_sin, rot_cos;
	logic signed [SW-1:0] spd_d [CORDIC_STEPS];

	assign rot_z = ZW'(phi_a1) <<< ZSH;

	awc_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_a1),
		.z_in      (rot_z),
		.out_valid (rot_valid),
		.sin_out   (rot_sin),
		.cos_out   (rot_cos)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			spd_d[0] <= spd_a1;
			for (int k = 1; k < CORDIC_STEPS; k++) begin
				spd_d[k] <= spd_d[k-1];
			end
		end
	end

	// ---------------- geometry products ----------------
	logic signed [15:0]       two_l, trk;
	logic signed [RW+15:0]    n_full, c_full, ws_full;
	logic signed [DW_IN-1:0]  n_m1, c2_m1, ws_m1;
	logic signed [SW-1:0]     spd_m1, spd_m2;
	logic                     v_m1, v_m2;
	logic signed [DW_IN-1:0]  n_m2, c2_m2, d0_m2, d1_m2;

	assign two_l   = $signed({1'b0, wheelbase_q, 1'b0});
	assign trk     = $signed({2'b0, track_q});
	assign n_full  = two_l * rot_sin;
	assign c_full  = two_l * rot_cos;
	assign ws_full = trk * rot_sin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m1 <= rot_valid;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_m1   <= n_full[DW_IN-1:0];
			c2_m1  <= c_full[DW_IN-1:0];
			ws_m1  <= ws_full[DW_IN-1:0];
			spd_m1 <= spd_d[CORDIC_STEPS-1];
			// inner/outer denominators 2Lc -/+ Ws
			n_m2   <= n_m1;
			c2_m2  <= c2_m1;
			d0_m2  <= c2_m1 - ws_m1;
			d1_m2  <= c2_m1 + ws_m1;
			spd_m2 <= spd_m1;
		end
	end

	// ---------------- steering angles ----------------
	logic signed [AW-1:0] left_raw, right_raw;
	ang_t                 ang_c1;
	ang_t                 ang_d [ANG_DLY];

	awc_vec u_vec_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.y_in      (n_m2),
		.x_in      (d0_m2),
		.out_valid (),
		.angle_out (left_raw)
	);

	awc_vec u_vec_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.y_in      (n_m2),
		.x_in      (d1_m2),
		.out_valid (),
		.angle_out (right_raw)
	);

	// clamp judged on the right wheel, mirrored for negative turns
	always_ff @(posedge clk) begin
		if (en) begin
			if (right_raw > $signed({2'b0, thr_q})) begin
				ang_c1.left_steer  <= AW'(outer_q);
				ang_c1.right_steer <= AW'(inner_q);
			end else if (right_raw < -$signed({2'b0, thr_q})) begin
				ang_c1.right_steer <= AW'(-$signed({1'b0, outer_q}));
				ang_c1.left_steer  <= AW'(-$signed({1'b0, inner_q}));
			end else begin
				ang_c1.left_steer  <= left_raw;
				ang_c1.right_steer <= right_raw;
			end
			ang_d[0] <= ang_c1;
			for (int k = 1; k < ANG_DLY; k++) begin
				ang_d[k] <= ang_d[k-1];
			end
		end
	end

	// ---------------- rear speed numerators ----------------
	logic signed [DW_IN-1:0] p0_r1, p1_r1;
	logic signed [29:0]      dd_r1;
	logic signed [SW-1:0]    spd_r1;
	logic                    v_r1, v_r2;
	logic                    dd_pos;
	logic [DIV_DW-1:0]       den1_c, den1_r2;
	logic [DW_IN-1:0]        ap0, ap1;
	logic [DIV_NW-1:0]       a0_r2, a1_r2;
	sb1_t                    sb1_r2;
	sb1_t                    sb1_d [DIV_NW];

	assign dd_pos = !dd_r1[29] && (dd_r1 != '0);
	assign den1_c = dd_pos ? dd_r1[DIV_DW-1:0] : DIV_DW'(1);
	assign ap0    = p0_r1[DW_IN-1] ? -p0_r1 : p0_r1;
	assign ap1    = p1_r1[DW_IN-1] ? -p1_r1 : p1_r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
		end else if (en) begin
			v_r1 <= v_m2;
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// operands scaled down by 2^16 before the divide
			p0_r1  <= spd_m2 * $signed(d0_m2[DW_IN-1:16]);
			p1_r1  <= spd_m2 * $signed(d1_m2[DW_IN-1:16]);
			dd_r1  <= $signed(c2_m2[DW_IN-1:16]);
			spd_r1 <= spd_m2;

			den1_r2       <= den1_c;
			a0_r2         <= (DIV_NW'(ap0) << 8) + DIV_NW'(den1_c >> 1);
			a1_r2         <= (DIV_NW'(ap1) << 8) + DIV_NW'(den1_c >> 1);
			sb1_r2.speed  <= spd_r1;
			sb1_r2.dd_pos <= dd_pos;
			sb1_r2.neg0   <= p0_r1[DW_IN-1];
			sb1_r2.neg1   <= p1_r1[DW_IN-1];

			sb1_d[0] <= sb1_r2;
			for (int k = 1; k < DIV_NW; k++) begin
				sb1_d[k] <= sb1_d[k-1];
			end
		end
	end

	logic              q1v;
	logic [DIV_NW-1:0] q10, q11;

	awc_div u_div_rl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r2),
		.dividend  (a0_r2),
		.divisor   (den1_r2),
		.out_valid (q1v),
		.quotient  (q10)
	);

	awc_div u_div_rr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r2),
		.dividend  (a1_r2),
		.divisor   (den1_r2),
		.out_valid (),
		.quotient  (q11)
	);

	// ---------------- rear speeds ----------------
	function automatic logic signed [41:0] rear_of(input logic [DIV_NW-1:0] q,
		input logic neg, input logic dd_ok, input logic signed [SW-1:0] spd);
		logic [40:0] qs;
		qs = (q > SPEED_LIM) ? SPEED_LIM[40:0] : q[40:0];
		if (!dd_ok) begin
			return 42'(spd) <<< 8;
		end else if (neg) begin
			return -$signed({1'b0, qs});
		end else begin
			return $signed({1'b0, qs});
		end
	endfunction

	logic signed [41:0]   rs0_r3, rs1_r3;
	logic signed [SW-1:0] spd_r3;
	logic                 v_r3, v_r4;
	logic                 rz;
	logic [DIV_DW-1:0]    den2_c, denf_c, den2_r4, denf_r4;
	logic [41:0]          ars0, ars1;
	logic [SW:0]          aspd;
	logic [DIV_NW-1:0]    a0_r4, a1_r4, af_r4;
	sb2_t                 sb2_r4;
	sb2_t                 sb2_d [DIV_NW];

	assign rz     = (radius_q == '0);
	assign den2_c = rz ? DIV_DW'(1) : DIV_DW'({radius_q, 9'b0});
	assign denf_c = rz ? DIV_DW'(1) : DIV_DW'({radius_q, 1'b0});
	assign ars0   = rs0_r3[41] ? -rs0_r3 : rs0_r3;
	assign ars1   = rs1_r3[41] ? -rs1_r3 : rs1_r3;
	assign aspd   = spd_r3[SW-1] ? -{spd_r3[SW-1], spd_r3} : {spd_r3[SW-1], spd_r3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r3 <= 1'b0;
			v_r4 <= 1'b0;
		end else if (en) begin
			v_r3 <= q1v;
			v_r4 <= v_r3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs0_r3 <= rear_of(q10, sb1_d[DIV_NW-1].neg0, sb1_d[DIV_NW-1].dd_pos,
				sb1_d[DIV_NW-1].speed);
			rs1_r3 <= rear_of(q11, sb1_d[DIV_NW-1].neg1, sb1_d[DIV_NW-1].dd_pos,
				sb1_d[DIV_NW-1].speed);
			spd_r3 <= sb1_d[DIV_NW-1].speed;

			// rate numerators scaled by 2^F, half divisor added for rounding
			den2_r4 <= den2_c;
			denf_r4 <= denf_c;
			a0_r4   <= (DIV_NW'(ars0[40:0]) << ANGLE_FRAC_BITS) + DIV_NW'(den2_c >> 1);
			a1_r4   <= (DIV_NW'(ars1[40:0]) << ANGLE_FRAC_BITS) + DIV_NW'(den2_c >> 1);
			af_r4   <= (DIV_NW'(aspd) << ANGLE_FRAC_BITS) + DIV_NW'(denf_c >> 1);
			sb2_r4.negf <= spd_r3[SW-1];
			sb2_r4.neg0 <= rs0_r3[41];
			sb2_r4.neg1 <= rs1_r3[41];

			sb2_d[0] <= sb2_r4;
			for (int k = 1; k < DIV_NW; k++) begin
				sb2_d[k] <= sb2_d[k-1];
			end
		end
	end

	logic              q2v;
	logic [DIV_NW-1:0] q2f, q20, q21;

	awc_div u_div_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r4),
		.dividend  (af_r4),
		.divisor   (denf_r4),
		.out_valid (q2v),
		.quotient  (q2f)
	);

	awc_div u_div_rate_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r4),
		.dividend  (a0_r4),
		.divisor   (den2_r4),
		.out_valid (),
		.quotient  (q20)
	);

	awc_div u_div_rate_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r4),
		.dividend  (a1_r4),
		.divisor   (den2_r4),
		.out_valid (),
		.quotient  (q21)
	);

	// ---------------- rate saturation ----------------
	// zero radius: divider ran with divisor 1, so q is just the magnitude
	function automatic logic signed [RTW-1:0] rate_of(input logic [DIV_NW-1:0] q,
		input logic neg, input logic zr);
		if (zr) begin
			if (q == '0) begin
				return '0;
			end else begin
				return neg ? RATE_MIN : RATE_MAX;
			end
		end else if (neg) begin
			return (q > RATE_NEG_LIM) ? RATE_MIN : -$signed(q[RTW-1:0]);
		end else begin
			return (q > RATE_POS_LIM) ? RATE_MAX : $signed(q[RTW-1:0]);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r5 <= 1'b0;
		end else if (en) begin
			v_r5 <= q2v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_r5.left_steer      <= ang_d[ANG_DLY-1].left_steer;
			res_r5.right_steer     <= ang_d[ANG_DLY-1].right_steer;
			res_r5.front_rate      <= rate_of(q2f, sb2_d[DIV_NW-1].negf, rz);
			res_r5.rear_left_rate  <= rate_of(q20, sb2_d[DIV_NW-1].neg0, rz);
			res_r5.rear_right_rate <= rate_of(q21, sb2_d[DIV_NW-1].neg1, rz);
		end
	end

	// ---------------- output buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_r5;
		end
	end

	assign m_tdata = buf_q[rd_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("word pushed into a full output buffer");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !m_tready) |=> (count_q == 2'd2))
		else $error("full output buffer changed without a pop");

endmodule

// ===== rtl/awc_rot.sv =====
// ----------------------------------------------------------------------------
// awc_rot
// Rotation-mode CORDIC pipeline, one micro-rotation per stage. Gives sin and
// cos scaled by the CORDIC gain (no correction).
// ----------------------------------------------------------------------------
module awc_rot (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [awc_pkg::ZW-1:0] z_in,
	output logic                         out_valid,
	output logic signed [awc_pkg::RW-1:0] sin_out,
	output logic signed [awc_pkg::RW-1:0] cos_out
);
	import awc_pkg::*;

	logic                 valid_s [CORDIC_STEPS];
	logic signed [RW-1:0] x_s     [CORDIC_STEPS];
	logic signed [RW-1:0] y_s     [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s     [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic                 vin;
		logic signed [RW-1:0] xin;
		logic signed [RW-1:0] yin;
		logic signed [ZW-1:0] zin;

		if (i == 0) begin : g_first
			assign vin = in_valid;
			assign xin = CORDIC_X0;
			assign yin = '0;
			assign zin = z_in;
		end else begin : g_next
			assign vin = valid_s[i-1];
			assign xin = x_s[i-1];
			assign yin = y_s[i-1];
			assign zin = z_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zin[ZW-1]) begin
					x_s[i] <= xin - (yin >>> i);
					y_s[i] <= yin + (xin >>> i);
					z_s[i] <= zin - atan_z(i);
				end else begin
					x_s[i] <= xin + (yin >>> i);
					y_s[i] <= yin - (xin >>> i);
					z_s[i] <= zin + atan_z(i);
				end
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS-1];
	assign sin_out   = y_s[CORDIC_STEPS-1];
	assign cos_out   = x_s[CORDIC_STEPS-1];

endmodule

// ===== rtl/awc_vec.sv =====
// ----------------------------------------------------------------------------
// awc_vec
// Vectoring-mode CORDIC atan2 pipeline: quarter-turn pre-rotation stage,
// one micro-rotation per stage, then rounding and saturation to the output angle scale.
// ----------------------------------------------------------------------------
module awc_vec (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [awc_pkg::DW_IN-1:0] y_in,
	input  logic signed [awc_pkg::DW_IN-1:0] x_in,
	output logic                            out_valid,
	output logic signed [awc_pkg::AW-1:0]    angle_out
);
	import awc_pkg::*;

	localparam logic signed [ZRW-1:0] HP = ZRW'(HP_OUT);

	logic signed [VW-1:0] xe, ye;
	logic signed [VW-1:0] px_c, py_c;
	logic signed [ZW-1:0] pz_c;

	logic                 pv_s1, pzero_s1;
	logic signed [VW-1:0] px_s1, py_s1;
	logic signed [ZW-1:0] pz_s1;

	logic                 valid_s [CORDIC_STEPS];
	logic                 zero_s  [CORDIC_STEPS];
	logic signed [VW-1:0] x_s     [CORDIC_STEPS];
	logic signed [VW-1:0] y_s     [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s     [CORDIC_STEPS];

	logic signed [ZRW-1:0] zr, za, zsel;
	logic                  ov_q;
	logic signed [AW-1:0]  angle_q;

	assign xe = VW'(x_in);
	assign ye = VW'(y_in);

	// left half plane: turn by a quarter so x is not negative
	always_comb begin
		if (x_in[DW_IN-1]) begin
			if (!y_in[DW_IN-1]) begin
				px_c = ye;
				py_c = -xe;
				pz_c = HALF_PI_Z;
			end else begin
				px_c = -ye;
				py_c = xe;
				pz_c = -HALF_PI_Z;
			end
		end else begin
			px_c = xe;
			py_c = ye;
			pz_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (en) begin
			pv_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= px_c;
			py_s1    <= py_c;
			pz_s1    <= pz_c;
			pzero_s1 <= (x_in == '0) && (y_in == '0);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic                 vin, zin_flag;
		logic signed [VW-1:0] xin, yin;
		logic signed [ZW-1:0] zin;

		if (i == 0) begin : g_first
			assign vin      = pv_s1;
			assign zin_flag = pzero_s1;
			assign xin      = px_s1;
			assign yin      = py_s1;
			assign zin      = pz_s1;
		end else begin : g_next
			assign vin      = valid_s[i-1];
			assign zin_flag = zero_s[i-1];
			assign xin      = x_s[i-1];
			assign yin      = y_s[i-1];
			assign zin      = z_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i] <= zin_flag;
				if (yin[VW-1]) begin
					x_s[i] <= xin - (yin >>> i);
					y_s[i] <= yin + (xin >>> i);
					z_s[i] <= zin - atan_z(i);
				end else begin
					x_s[i] <= xin + (yin >>> i);
					y_s[i] <= yin - (xin >>> i);
					z_s[i] <= zin + atan_z(i);
				end
			end
		end
	end

	// round to output scale, saturate to +-pi/2
	assign zr = ZRW'(z_s[CORDIC_STEPS-1]) + ZRW'(1 << (ZSH - 1));
	assign za = zr >>> ZSH;

	always_comb begin
		if (zero_s[CORDIC_STEPS-1]) begin
			zsel = '0;
		end else if (za > HP) begin
			zsel = HP;
		end else if (za < -HP) begin
			zsel = -HP;
		end else begin
			zsel = za;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= valid_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= AW'(zsel);
		end
	end

	assign out_valid = ov_q;
	assign angle_out = angle_q;

endmodule

// ===== rtl/awc_div.sv =====
// ----------------------------------------------------------------------------
// awc_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Unsigned; the divisor must be nonzero for a valid word.
// ----------------------------------------------------------------------------
module awc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [awc_pkg::DIV_NW-1:0]    dividend,
	input  logic [awc_pkg::DIV_DW-1:0]    divisor,
	output logic                          out_valid,
	output logic [awc_pkg::DIV_NW-1:0]    quotient
);
	import awc_pkg::*;

	logic              valid_s [DIV_NW];
	logic [DIV_DW-1:0] rem_s   [DIV_NW];
	logic [DIV_NW-1:0] aq_s    [DIV_NW];
	logic [DIV_DW-1:0] den_s   [DIV_NW];

	for (genvar i = 0; i < DIV_NW; i++) begin : g_stage
		logic              vin, ge;
		logic [DIV_DW-1:0] remin, denin;
		logic [DIV_NW-1:0] aqin;
		logic [DIV_DW:0]   t, tsub;

		if (i == 0) begin : g_first
			assign vin   = in_valid;
			assign remin = '0;
			assign aqin  = dividend;
			assign denin = divisor;
		end else begin : g_next
			assign vin   = valid_s[i-1];
			assign remin = rem_s[i-1];
			assign aqin  = aq_s[i-1];
			assign denin = den_s[i-1];
		end

		assign t    = {remin, aqin[DIV_NW-1]};
		assign ge   = t >= {1'b0, denin};
		assign tsub = t - {1'b0, denin};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? tsub[DIV_DW-1:0] : t[DIV_DW-1:0];
				aq_s[i]  <= {aqin[DIV_NW-2:0], ge};
				den_s[i] <= denin;
			end
		end
	end

	assign out_valid = valid_s[DIV_NW-1];
	assign quotient  = aq_s[DIV_NW-1];

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |-> (divisor != '0))
		else $error("divider fed a zero divisor");

endmodule
